// File: rtl/itdt_pkg.sv
package itdt_pkg;

  // width of the input field, and the bits of it that are converted
  localparam int unsigned ValueW     = 32;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned CharW  = 6;
  localparam int unsigned DigitW = 4;

  localparam logic [CharW-1:0] ASCII_ZERO  = CharW'(48);
  localparam logic [CharW-1:0] ASCII_MINUS = CharW'(45);

  // decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
  function automatic int unsigned digits_for(input int unsigned bits);
    longint unsigned max_mag;
    longint unsigned pow;
    int unsigned     n;
    max_mag = longint'(1) << (bits - 1);
    pow     = 10;
    n       = 1;
    while (pow <= max_mag) begin
      pow = pow * 10;
      n   = n + 1;
    end
    return n;
  endfunction

  localparam int unsigned NumDigits = digits_for(VALUE_BITS);
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned CntW      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned NdigW     = $clog2(NumDigits + 1);

  typedef logic [BcdW-1:0] bcd_t;

endpackage

// File: rtl/int_to_decimal_text.sv
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-----------------------------
// in       | input     | in_valid_i / in_ready_o   | value_i (32b signed)
// out      | output    | out_valid_o / out_ready_i | char_code_o (6b), last_char_o
//
// one request: accept, then bit-serial double dabble over the VALUE_BITS (32) magnitude bits,
// then leading zero digits are dropped one per cycle (0 to 9), then the text goes out one
// character per cycle while the output is free (1 to 11); zeros dropped and digits sent
// add up to NumDigits.
// the last character waits in the output register while the next request is taken.
// a stalled output holds the emit sequencer, reset (rst_ni low) returns to idle.
module int_to_decimal_text
  import itdt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic        [CharW-1:0]  char_code_o,
  output logic                     last_char_o
);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1; // double dabble, one magnitude bit per cycle
  localparam logic [1:0] S_SKIP = 2'd2; // drop leading zero digits, one per cycle
  localparam logic [1:0] S_EMIT = 2'd3; // sign, then one digit per cycle while the output slot is free

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  bcd_t                  bcd_q, bcd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [NdigW-1:0]      ndig_q, ndig_d;
  logic                  neg_q, neg_d;

  logic                  out_valid_q, out_valid_d;
  logic [CharW-1:0]      char_q, char_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  bcd_t                  bcd_adj;
  logic [DigitW-1:0]     top_digit;
  logic                  slot_free;

  assign raw       = value_i[VALUE_BITS-1:0];
  assign raw_neg   = raw[VALUE_BITS-1];
  assign top_digit = bcd_q[BcdW-1 -: DigitW];
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  // add 3 to every bcd digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd_q[d*DigitW +: DigitW] >= DigitW'(5)) begin
        bcd_adj[d*DigitW +: DigitW] = bcd_q[d*DigitW +: DigitW] + DigitW'(3);
      end else begin
        bcd_adj[d*DigitW +: DigitW] = bcd_q[d*DigitW +: DigitW];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    // output slot drains on the handshake
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // magnitude through an unsigned negate, safe for the most negative value
          mag_d   = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;
          neg_d   = raw_neg;
          bcd_d   = '0;
          cnt_d   = CntW'(VALUE_BITS - 1);
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = {bcd_adj[BcdW-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          ndig_d  = NdigW'(NumDigits);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if (top_digit == '0 && ndig_q != NdigW'(1)) begin
          bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d = ndig_q - NdigW'(1);
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            char_d = ASCII_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = ASCII_ZERO + CharW'(top_digit);
            last_d = (ndig_q == NdigW'(1));
            bcd_d  = {bcd_q[BcdW-DigitW-1:0], {DigitW{1'b0}}};
            ndig_d = ndig_q - NdigW'(1);
            if (ndig_q == NdigW'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // a minus sign never ends the text
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_code_o == ASCII_MINUS |-> !last_char_o)
    else $error("minus sign flagged as last character");

  // only a minus or a digit ever leaves the block
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_code_o == ASCII_MINUS ||
      (char_code_o >= ASCII_ZERO && char_code_o <= ASCII_ZERO + CharW'(9)))
    else $error("character code out of range");

  // an accepted request starts conversion next cycle
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CONV)
    else $error("accepted request did not start conversion");

  // the digit count never runs out before the last digit goes out
  a_ndig_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SKIP || state_q == S_EMIT |-> ndig_q != '0)
    else $error("digit count empty while emitting");

endmodule

// File: test/int_to_decimal_text_tb.sv
// scoreboard: predicts the text of each accepted request and checks the characters in order
class decimal_text_checker;

  typedef struct packed {
    logic [itdt_pkg::CharW-1:0] code;
    logic                       last;
  } text_char_t;

  // characters still awaited, oldest first
  text_char_t awaited_chars[$];
  int         mismatches;

  function new();
    mismatches = 0;
  endfunction

  // expected text of one accepted request: sign, then digits msd first
  function void note_value(logic signed [itdt_pkg::ValueW-1:0] value);
    logic [itdt_pkg::VALUE_BITS-1:0] raw;
    logic [itdt_pkg::VALUE_BITS-1:0] mag_bits;
    longint unsigned                 mag;
    byte unsigned                    digits_lsd[$];
    logic                            negative;
    text_char_t                      ch;
    raw      = value[itdt_pkg::VALUE_BITS-1:0];
    negative = raw[itdt_pkg::VALUE_BITS-1];
    mag_bits = negative ? (~raw + 1'b1) : raw;
    mag      = longint'(mag_bits);
    do begin
      digits_lsd.push_back(byte'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (negative) begin
      ch.code = itdt_pkg::ASCII_MINUS;
      ch.last = 1'b0;
      awaited_chars.push_back(ch);
    end
    for (int i = digits_lsd.size() - 1; i >= 0; i--) begin
      ch.code = itdt_pkg::ASCII_ZERO + itdt_pkg::CharW'(digits_lsd[i]);
      ch.last = (i == 0);
      awaited_chars.push_back(ch);
    end
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_char(logic [itdt_pkg::CharW-1:0] code, logic last);
    text_char_t want;
    if (awaited_chars.size() == 0) begin
      report_mismatch($sformatf("char %0d last %0b with nothing awaited", code, last));
    end else begin
      want = awaited_chars.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("char_code %0d, want %0d", code, want.code));
      if (last !== want.last)
        report_mismatch($sformatf("last_char %0b, want %0b (char %0d)",
                                  last, want.last, want.code));
    end
  endtask

  function int awaited_count();
    return awaited_chars.size();
  endfunction

endclass

module int_to_decimal_text_tb;
  import itdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no request or character moving before the run is abandoned;
  // stalls and gaps are short random runs
  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned RandPerPhase = 112;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ValueW-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic        [CharW-1:0]  char_code_o;
  logic                     last_char_o;

  // idle and stall chances in percent per cycle, set per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  decimal_text_checker board = new();

  int_to_decimal_text dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // offer one request: optional idle gap first, then hold valid and value
  // until the block takes it; inputs only move on the falling edge
  task automatic send_value(input logic signed [ValueW-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(9) == 0) begin
      // an occasional long pause so gaps also cover the busy and emit phases
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk_i);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_i    = value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_value(value);
    @(negedge clk_i);
  endtask

  // random value with a chosen number of decimal digits and a random sign,
  // so short and long texts both show up often
  function automatic logic signed [ValueW-1:0] shaped_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int unsigned     ndig;
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        // neighbors of powers of ten
        ndig = $urandom_range(0, 9);
        lo   = 1;
        repeat (ndig) lo = lo * 10;
        mag  = lo + $urandom_range(0, 2) - 1;
        if ($urandom_range(1)) return -ValueW'(mag);
        return ValueW'(mag);
      end
      default: begin
        ndig = $urandom_range(1, 10);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = (ndig == 1) ? 9 : lo * 10 - 1;
        if (ndig == 1) lo = 0;
        // magnitude up to 2^31 so the most negative value is reachable
        if (hi > 64'h8000_0000) hi = 64'h8000_0000;
        mag  = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
        if ($urandom_range(1)) return -ValueW'(mag);
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return ValueW'(mag);
      end
    endcase
  endfunction

  // receiver: ready changes on the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every accepted character goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_char(char_code_o, last_char_o);
    end
  end

  // watchdog: abandons the run once nothing has moved for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StuckLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no request or character moved for %0d cycles", StuckLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic signed [ValueW-1:0] directed[$];
    int unsigned              idle_by_phase[4];
    int unsigned              stall_by_phase[4];
    idle_by_phase  = '{0, 60, 0, 28};
    stall_by_phase = '{0, 0, 60, 28};
    // zero, single digits, powers of ten and their neighbors, both extremes
    // (the most negative value needs the unsigned magnitude), alternating bits
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -54321,
                 999999999, 1000000000, -1000000000, 1234567890,
                 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh5555_5555, 32'shAAAA_AAAA, -2};

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    value_i    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed requests with both sides running freely
    foreach (directed[i]) send_value(directed[i]);

    // random requests under each idling pattern
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      for (int n = 0; n < RandPerPhase; n++) send_value(shaped_value());
    end
    in_valid_i = 1'b0;

    // let the last characters drain, then watch for anything extra
    while (board.awaited_count() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
